### rtl/ppfs_pkg.sv
package ppfs_pkg;

    localparam int MAX_SLOTS = 256;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int COORD_W   = 16;
    localparam int PORT_W    = 16;
    localparam int SEL_W     = 8;
    localparam int AGE_W     = 8;
    localparam int LIMIT_W   = 8;
    localparam int SLOTS_W   = 9;
    localparam int CNT_W     = (SLOTS_W > SLOT_W + 1) ? SLOTS_W : SLOT_W + 1;
    localparam int CMP_W     = (SEL_W > SLOT_W) ? SEL_W : SLOT_W;
    localparam int WIDE_W    = 34;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 104;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = 120;
    localparam int M_USER_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPLASH_LIMIT = 4'd1;

    localparam logic [SLOTS_W-1:0] SLOTS_RESET = 9'd256;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd30;

    localparam logic signed [WIDE_W-1:0] COORD_MAX =
        {{(WIDE_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
    localparam logic signed [WIDE_W-1:0] COORD_MIN = ~COORD_MAX;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SPAWN = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_TICK_DONE = 2'd0,
        STAT_SPAWNED   = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_READ_DATA = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MODE_DEAD   = 2'd0,
        MODE_FALL   = 2'd1,
        MODE_SPLASH = 2'd2
    } mode_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } ctrl_state_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    // One command travelling down the row of slot cells.
    typedef struct packed {
        logic                   valid;
        op_t                    op;
        logic [SEL_W-1:0]       sel;
        logic [SLOT_W-1:0]      idx;
        logic                   found;
        logic [SLOT_W-1:0]      found_idx;
        mode_t                  mode;
        coord_t [2:0]           pos;
        coord_t [2:0]           vel;
        logic [AGE_W-1:0]       age;
    } tok_t;

    typedef struct packed {
        logic                   advance;
        logic [SLOT_W:0]        n_active;
        logic [LIMIT_W-1:0]     splash_limit;
    } cell_ctrl_t;

    function automatic coord_t sat_coord(input logic signed [WIDE_W-1:0] v);
        coord_t r;
        if (v > COORD_MAX) begin
            r = COORD_MAX[COORD_W-1:0];
        end else if (v < COORD_MIN) begin
            r = COORD_MIN[COORD_W-1:0];
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    function automatic coord_t sat_add(input coord_t a, input coord_t b);
        logic signed [WIDE_W-1:0] s;
        s = WIDE_W'(a) + WIDE_W'(b);
        return sat_coord(s);
    endfunction

    function automatic coord_t from_port(input logic signed [PORT_W-1:0] p);
        return sat_coord(WIDE_W'(p));
    endfunction

    function automatic logic [PORT_W-1:0] to_port(input coord_t c);
        logic signed [WIDE_W-1:0] w;
        w = WIDE_W'(c);
        return w[PORT_W-1:0];
    endfunction

endpackage

### rtl/ppfs_cell.sv
module ppfs_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ppfs_pkg::cell_ctrl_t ctrl,
    input  ppfs_pkg::tok_t       tok_in,
    output ppfs_pkg::tok_t       tok_out
);

    ppfs_pkg::mode_t                     mode_reg, mode_next;
    ppfs_pkg::coord_t [2:0]              pos_reg, pos_next;
    ppfs_pkg::coord_t [2:0]              vel_reg, vel_next;
    logic [ppfs_pkg::AGE_W-1:0]          age_reg, age_next;
    ppfs_pkg::tok_t                      tok_reg, tok_next;

    ppfs_pkg::coord_t [2:0]              pos_sum;
    logic [ppfs_pkg::AGE_W:0]            age_inc;
    logic                                in_use;
    logic                                sel_hit;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pos_sum[k] = ppfs_pkg::sat_add(pos_reg[k], vel_reg[k]);
        end
        age_inc = {1'b0, age_reg} + (ppfs_pkg::AGE_W+1)'(1);
        in_use  = {1'b0, tok_in.idx} < ctrl.n_active;
        sel_hit = ppfs_pkg::CMP_W'(tok_in.sel) == ppfs_pkg::CMP_W'(tok_in.idx);

        mode_next = mode_reg;
        pos_next  = pos_reg;
        vel_next  = vel_reg;
        age_next  = age_reg;
        tok_next  = tok_reg;

        if (ctrl.advance) begin
            tok_next     = tok_in;
            tok_next.idx = tok_in.idx + ppfs_pkg::SLOT_W'(1);
            if (tok_in.valid) begin
                unique case (tok_in.op)
                    ppfs_pkg::OP_TICK: begin
                        if (in_use) begin
                            unique case (mode_reg)
                                ppfs_pkg::MODE_FALL: begin
                                    pos_next = pos_sum;
                                    // Height at or below the ground ends the fall.
                                    if (pos_sum[1][ppfs_pkg::COORD_W-1] || pos_sum[1] == '0) begin
                                        mode_next = ppfs_pkg::MODE_SPLASH;
                                        age_next  = '0;
                                        vel_next  = '0;
                                    end
                                end
                                ppfs_pkg::MODE_SPLASH: begin
                                    age_next = age_inc[ppfs_pkg::AGE_W] ? '1
                                                                        : age_inc[ppfs_pkg::AGE_W-1:0];
                                    if (age_inc > {1'b0, ctrl.splash_limit}) begin
                                        mode_next = ppfs_pkg::MODE_DEAD;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                    ppfs_pkg::OP_SPAWN: begin
                        if (in_use && !tok_in.found && mode_reg == ppfs_pkg::MODE_DEAD) begin
                            mode_next          = ppfs_pkg::MODE_FALL;
                            age_next           = '0;
                            pos_next           = tok_in.pos;
                            vel_next           = tok_in.vel;
                            tok_next.found     = 1'b1;
                            tok_next.found_idx = tok_in.idx;
                        end
                    end
                    ppfs_pkg::OP_READ: begin
                        if (sel_hit) begin
                            tok_next.mode = mode_reg;
                            tok_next.pos  = pos_reg;
                            tok_next.vel  = vel_reg;
                            tok_next.age  = age_reg;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= ppfs_pkg::MODE_DEAD;
            pos_reg       <= '0;
            vel_reg       <= '0;
            age_reg       <= '0;
            tok_reg.valid <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            vel_reg  <= vel_next;
            age_reg  <= age_next;
            tok_reg  <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

### rtl/particle_pool_fall_splash.sv
// Particle pool: a row of slot cells, each holding one particle that is dead,
// falling or splashing. A command beat enters on the s_ channel with its
// opcode in s_tuser: tick updates every slot in use, spawn fills the first
// dead slot in use, read returns one slot. One result beat per command leaves
// on the m_ channel with its status in m_tuser.
// The command walks the row one cell per cycle; when it leaves the last cell
// its result is registered in the output register, and the next command is
// taken only after that: the block takes no new command before the last one
// has left the row. Only one command is in the row at a time.
// The result sits in an output register; a stalled receiver does not block the
// next command, which walks the row and then waits in the last cell until the
// output register is free, holding every cell meanwhile.
// Configuration writes on the cfg_ channel are always ready and are meant for
// an idle block. Reset clears every slot to dead with zero contents and sets
// slots_in_use to 256 and splash_limit to 30; the block is ready at once.
module particle_pool_fall_splash (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // slot_index, start_x, start_y, start_z, speed_x, speed_y, speed_z
    input  logic [ppfs_pkg::S_DATA_W-1:0]      s_tdata,
    // opcode
    input  logic [ppfs_pkg::S_USER_W-1:0]      s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // slot_number, slot_mode, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
    // splash_age, zero fill
    output logic [ppfs_pkg::M_DATA_W-1:0]      m_tdata,
    // status
    output logic [ppfs_pkg::M_USER_W-1:0]      m_tuser,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ppfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppfs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PW = ppfs_pkg::PORT_W;

    ppfs_pkg::ctrl_state_t                 state_reg, state_next;
    logic [ppfs_pkg::SLOTS_W-1:0]          slots_in_use_reg;
    logic [ppfs_pkg::LIMIT_W-1:0]          splash_limit_reg;
    logic                                  out_valid_reg, out_valid_next;
    logic [ppfs_pkg::M_DATA_W-1:0]         out_data_reg, out_data_next;
    logic [ppfs_pkg::M_USER_W-1:0]         out_user_reg, out_user_next;

    ppfs_pkg::tok_t                        tok_chain [ppfs_pkg::MAX_SLOTS+1];
    ppfs_pkg::tok_t                        tok_last;
    ppfs_pkg::cell_ctrl_t                  ctrl;
    logic [ppfs_pkg::CNT_W-1:0]            slots_ext;
    logic                                  s_accept;
    logic                                  take_last;
    ppfs_pkg::op_t                         in_op;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slots_in_use_reg <= ppfs_pkg::SLOTS_RESET;
            splash_limit_reg <= ppfs_pkg::LIMIT_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == ppfs_pkg::REG_SLOTS_IN_USE) begin
                slots_in_use_reg <= cfg_data[ppfs_pkg::SLOTS_W-1:0];
            end else if (cfg_index == ppfs_pkg::REG_SPLASH_LIMIT) begin
                splash_limit_reg <= cfg_data[ppfs_pkg::LIMIT_W-1:0];
            end
        end
    end

    assign slots_ext = ppfs_pkg::CNT_W'(slots_in_use_reg);
    assign tok_last  = tok_chain[ppfs_pkg::MAX_SLOTS];

    // The row holds still while a finished command waits for the output register.
    always_comb begin
        ctrl.advance      = !tok_last.valid || !out_valid_reg || m_tready;
        ctrl.n_active     = (slots_ext > ppfs_pkg::CNT_W'(ppfs_pkg::MAX_SLOTS))
                          ? (ppfs_pkg::SLOT_W+1)'(ppfs_pkg::MAX_SLOTS)
                          : slots_ext[ppfs_pkg::SLOT_W:0];
        ctrl.splash_limit = splash_limit_reg;
    end

    assign take_last = tok_last.valid && ctrl.advance;
    assign s_accept  = s_tvalid && s_tready;
    assign in_op     = ppfs_pkg::op_t'(s_tuser[1:0]);

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ppfs_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ppfs_pkg::ST_WALK;
                end
            end
            ppfs_pkg::ST_WALK: begin
                if (take_last) begin
                    state_next = ppfs_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ppfs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Command entering the first cell.
    always_comb begin
        tok_chain[0]           = '0;
        tok_chain[0].valid     = s_accept;
        tok_chain[0].op        = in_op;
        tok_chain[0].sel       = s_tdata[7:0];
        tok_chain[0].mode      = ppfs_pkg::MODE_DEAD;
        if (in_op == ppfs_pkg::OP_SPAWN) begin
            for (int k = 0; k < 3; k++) begin
                tok_chain[0].pos[k] = ppfs_pkg::from_port(s_tdata[8 + PW*k +: PW]);
                tok_chain[0].vel[k] = ppfs_pkg::from_port(s_tdata[8 + PW*(k+3) +: PW]);
            end
        end
    end

    for (genvar i = 0; i < ppfs_pkg::MAX_SLOTS; i++) begin : g_cell
        ppfs_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .tok_in  (tok_chain[i]),
            .tok_out (tok_chain[i+1])
        );
    end

    always_comb begin
        out_data_next = '0;
        out_user_next = ppfs_pkg::STAT_TICK_DONE;
        unique case (tok_last.op)
            ppfs_pkg::OP_SPAWN: begin
                if (tok_last.found) begin
                    out_user_next      = ppfs_pkg::STAT_SPAWNED;
                    out_data_next[7:0] = ppfs_pkg::SEL_W'(tok_last.found_idx);
                end else begin
                    out_user_next = ppfs_pkg::STAT_FULL;
                end
            end
            ppfs_pkg::OP_READ: begin
                out_user_next      = ppfs_pkg::STAT_READ_DATA;
                out_data_next[7:0] = tok_last.sel;
                out_data_next[9:8] = tok_last.mode;
                for (int k = 0; k < 3; k++) begin
                    out_data_next[10 + PW*k +: PW]     = ppfs_pkg::to_port(tok_last.pos[k]);
                    out_data_next[10 + PW*(k+3) +: PW] = ppfs_pkg::to_port(tok_last.vel[k]);
                end
                out_data_next[113:106] = tok_last.age;
            end
            default: begin
            end
        endcase

        out_valid_next = out_valid_reg;
        if (take_last) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take_last) begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

### test/particle_pool_monitor.sv
`timescale 1ns / 100ps

module particle_pool_monitor
    import ppfs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic [S_USER_W-1:0]   s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_DATA_W-1:0]   m_tdata,
    input  logic [M_USER_W-1:0]   m_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    error_count,
    output int                    reports_pending
);

    typedef struct packed {
        logic [1:0]         status;
        logic [SEL_W-1:0]   slot;
        logic [1:0]         mode;
        logic [PORT_W-1:0]  px;
        logic [PORT_W-1:0]  py;
        logic [PORT_W-1:0]  pz;
        logic [PORT_W-1:0]  vx;
        logic [PORT_W-1:0]  vy;
        logic [PORT_W-1:0]  vz;
        logic [AGE_W-1:0]   age;
    } slot_report_t;

    logic [SLOTS_W-1:0] slots_in_use;
    logic [LIMIT_W-1:0] splash_limit;

    mode_t              life         [MAX_SLOTS];
    logic [COORD_W-1:0] place        [MAX_SLOTS][3];
    logic [COORD_W-1:0] drift        [MAX_SLOTS][3];
    logic [AGE_W-1:0]   splash_ticks [MAX_SLOTS];

    slot_report_t awaited_reports [$];
    int           fails = 0;

    assign error_count = fails;

    // Applies one command beat to the pool copy and returns the report it should produce.
    function automatic slot_report_t apply_command(input logic [S_USER_W-1:0] op,
                                                   input logic [S_DATA_W-1:0] d);
        slot_report_t r;
        int           reach;
        int           i;
        int           k;
        logic [16:0]  wide;
        logic [8:0]   next_age;
        logic [7:0]   sel;
        bit           found;
        r = '0;
        sel = '0;
        found = 1'b0;
        reach = (slots_in_use > MAX_SLOTS) ? MAX_SLOTS : int'(slots_in_use);
        case (op_t'(op))
            OP_TICK: begin
                r.status = STAT_TICK_DONE;
                for (i = 0; i < reach; i++) begin
                    if (life[i] == MODE_FALL) begin
                        for (k = 0; k < 3; k++) begin
                            wide = {place[i][k][COORD_W-1], place[i][k]} +
                                   {drift[i][k][COORD_W-1], drift[i][k]};
                            // Overflow shows as the two top bits of the sum disagreeing.
                            place[i][k] = (wide[16] != wide[15]) ?
                                          {wide[16], {15{~wide[16]}}} : wide[15:0];
                        end
                        if (place[i][1][COORD_W-1] || place[i][1] == '0) begin
                            life[i] = MODE_SPLASH;
                            splash_ticks[i] = '0;
                            for (k = 0; k < 3; k++) drift[i][k] = '0;
                        end
                    end else if (life[i] == MODE_SPLASH) begin
                        next_age = {1'b0, splash_ticks[i]} + 9'd1;
                        splash_ticks[i] = next_age[8] ? 8'hFF : next_age[7:0];
                        if (next_age > {1'b0, splash_limit}) life[i] = MODE_DEAD;
                    end
                end
            end
            OP_SPAWN: begin
                for (i = 0; i < reach && !found; i++) begin
                    if (life[i] == MODE_DEAD) begin
                        found = 1'b1;
                        sel = 8'(i);
                    end
                end
                if (found) begin
                    life[sel] = MODE_FALL;
                    splash_ticks[sel] = '0;
                    for (k = 0; k < 3; k++) begin
                        place[sel][k] = d[8 + 16*k +: 16];
                        drift[sel][k] = d[56 + 16*k +: 16];
                    end
                    r.status = STAT_SPAWNED;
                    r.slot = sel;
                end else begin
                    r.status = STAT_FULL;
                end
            end
            OP_READ: begin
                sel = d[7:0];
                r.status = STAT_READ_DATA;
                r.slot = sel;
                r.mode = life[sel];
                r.px = place[sel][0];
                r.py = place[sel][1];
                r.pz = place[sel][2];
                r.vx = drift[sel][0];
                r.vy = drift[sel][1];
                r.vz = drift[sel][2];
                r.age = splash_ticks[sel];
            end
            default: begin
                r.status = STAT_TICK_DONE;
            end
        endcase
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            fails++;
        end
    endtask

    always @(posedge aclk) begin : watch
        slot_report_t want;
        slot_report_t got;
        if (!aresetn) begin
            slots_in_use = SLOTS_RESET;
            splash_limit = LIMIT_RESET;
            for (int i = 0; i < MAX_SLOTS; i++) begin
                life[i] = MODE_DEAD;
                splash_ticks[i] = '0;
                for (int k = 0; k < 3; k++) begin
                    place[i][k] = '0;
                    drift[i][k] = '0;
                end
            end
            awaited_reports.delete();
        end else begin
            // The result beat is matched before a command beat of the same edge is queued.
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.slot = m_tdata[7:0];
                got.mode = m_tdata[9:8];
                got.px = m_tdata[25:10];
                got.py = m_tdata[41:26];
                got.pz = m_tdata[57:42];
                got.vx = m_tdata[73:58];
                got.vy = m_tdata[89:74];
                got.vz = m_tdata[105:90];
                got.age = m_tdata[113:106];
                if (awaited_reports.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual tuser %h tdata %h",
                             $time, m_tuser, m_tdata);
                    fails++;
                end else begin
                    want = awaited_reports.pop_front();
                    compare_field("status", want.status, got.status);
                    compare_field("slot_number", want.slot, got.slot);
                    compare_field("slot_mode", want.mode, got.mode);
                    compare_field("pos_x", want.px, got.px);
                    compare_field("pos_y", want.py, got.py);
                    compare_field("pos_z", want.pz, got.pz);
                    compare_field("vel_x", want.vx, got.vx);
                    compare_field("vel_y", want.vy, got.vy);
                    compare_field("vel_z", want.vz, got.vz);
                    compare_field("splash_age", want.age, got.age);
                    compare_field("zero fill", '0, 16'(m_tdata[M_DATA_W-1:114]));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SLOTS_IN_USE: slots_in_use = cfg_data[SLOTS_W-1:0];
                    REG_SPLASH_LIMIT: splash_limit = cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                awaited_reports.push_back(apply_command(s_tuser, s_tdata));
            end
        end
        reports_pending = awaited_reports.size();
    end

endmodule

### test/particle_pool_fall_splash_test.sv
`timescale 1ns / 100ps

module particle_pool_fall_splash_test;
    import ppfs_pkg::*;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // slot_index, start_x, start_y, start_z, speed_x, speed_y, speed_z
    logic [S_DATA_W-1:0]   s_tdata;
    // opcode
    logic [S_USER_W-1:0]   s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // slot_number, slot_mode, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, splash_age, zero fill
    logic [M_DATA_W-1:0]   m_tdata;
    // status
    logic [M_USER_W-1:0]   m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int error_count;
    int reports_pending;
    bit steady = 1'b0;

    particle_pool_fall_splash dut (.*);

    particle_pool_monitor monitor_i (.*);

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    // Result side: a stall is drawn per beat and starts once a beat is waiting.
    initial begin : result_sink
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                m_tready = 1'b0;
                while (!m_tvalid) @(negedge aclk);
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    task automatic send_command(input op_t op, input logic [7:0] idx,
                                input logic [15:0] sx, input logic [15:0] sy,
                                input logic [15:0] sz, input logic [15:0] vx,
                                input logic [15:0] vy, input logic [15:0] vz);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            // Count the gap from the point the block is ready, so it lands near the handshake.
            s_tvalid = 1'b0;
            while (!s_tready) @(negedge aclk);
            repeat (gap) @(negedge aclk);
        end
        s_tuser = op;
        s_tdata = {vz, vy, vx, sz, sy, sx, idx};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // A spawn that starts low and heads down, so it reaches the splash phase quickly.
    task automatic send_falling_spawn();
        send_command(OP_SPAWN, 8'($urandom()), 16'($urandom()),
                     16'($urandom_range(0, 16'h0800)), 16'($urandom()), 16'($urandom()),
                     16'(-$urandom_range(16'h0080, 16'h0400)), 16'($urandom()));
    endtask

    task automatic random_command(input int reach, input int tick_pct, input int spawn_pct);
        int          pick;
        int          span;
        logic [15:0] noise [6];
        logic [7:0]  idx;
        pick = $urandom_range(0, 99);
        foreach (noise[k]) noise[k] = 16'($urandom());
        span = (reach > MAX_SLOTS) ? MAX_SLOTS : reach;
        idx = ($urandom_range(0, 4) == 0) ? 8'($urandom()) : 8'($urandom_range(0, span - 1));
        if (pick < 2) begin
            send_command(OP_NOP, idx, noise[0], noise[1], noise[2], noise[3], noise[4], noise[5]);
        end else if (pick < 2 + tick_pct) begin
            send_command(OP_TICK, idx, noise[0], noise[1], noise[2], noise[3], noise[4], noise[5]);
        end else if (pick < 2 + tick_pct + spawn_pct) begin
            if ($urandom_range(0, 3) != 0) begin
                send_falling_spawn();
            end else begin
                send_command(OP_SPAWN, idx, noise[0], noise[1], noise[2], noise[3], noise[4],
                             noise[5]);
            end
        end else begin
            send_command(OP_READ, idx, noise[0], noise[1], noise[2], noise[3], noise[4], noise[5]);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int value);
        cfg_index = index;
        cfg_data = 16'(value);
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (reports_pending != 0) @(negedge aclk);
    endtask

    task automatic run_phase(input int slots, input int limit, input int count,
                             input int tick_pct, input int spawn_pct, input bit calm);
        drain();
        write_reg(REG_SLOTS_IN_USE, slots);
        write_reg(REG_SPLASH_LIMIT, limit);
        steady = calm;
        repeat (count) random_command(slots, tick_pct, spawn_pct);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Empty pool after reset, the unused opcode and a tick with nothing alive.
        send_command(OP_READ, 8'h00, '0, '0, '0, '0, '0, '0);
        send_command(OP_READ, 8'hFF, '1, '1, '1, '1, '1, '1);
        send_command(OP_NOP, 8'hFF, '1, '1, '1, '1, '1, '1);
        send_command(OP_TICK, 8'h5A, 16'hA5A5, '1, 16'h5A5A, '0, '1, 16'h1234);

        // Spawns with extreme positions and speeds: saturation on every axis and both ways
        // on height, a slot sitting at height zero and one at the lowest height.
        send_command(OP_SPAWN, 8'h00, 16'h8000, 16'h0100, 16'h7FFF, 16'h7FFF, 16'hFF80, 16'h8000);
        send_command(OP_SPAWN, 8'hFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0001, 16'h7FFF, 16'hFFFF);
        send_command(OP_SPAWN, 8'h00, '0, '0, '0, '0, '0, '0);
        send_command(OP_SPAWN, 8'hAA, 16'h5555, 16'h8000, 16'hAAAA, 16'hAAAA, 16'h8000, 16'h5555);
        send_command(OP_TICK, 8'h00, '0, '0, '0, '0, '0, '0);
        send_command(OP_READ, 8'h00, '0, '0, '0, '0, '0, '0);
        send_command(OP_READ, 8'h01, '0, '0, '0, '0, '0, '0);
        send_command(OP_TICK, 8'h00, '0, '0, '0, '0, '0, '0);
        send_command(OP_READ, 8'h00, '0, '0, '0, '0, '0, '0);
        send_command(OP_READ, 8'h01, '0, '0, '0, '0, '0, '0);
        send_command(OP_READ, 8'h02, '0, '0, '0, '0, '0, '0);
        send_command(OP_READ, 8'h03, '0, '0, '0, '0, '0, '0);

        // No slots in use: spawn reports full and a tick leaves everything alone.
        drain();
        write_reg(REG_SPLASH_LIMIT, 0);
        write_reg(REG_SLOTS_IN_USE, 0);
        send_command(OP_SPAWN, 8'h00, 16'h0100, 16'h0100, '0, '0, 16'hFF00, '0);
        send_command(OP_TICK, 8'h00, '0, '0, '0, '0, '0, '0);
        send_command(OP_READ, 8'h02, '0, '0, '0, '0, '0, '0);

        // One slot with limit zero: the splash dies on its first tick, then the pool fills.
        drain();
        write_reg(REG_SLOTS_IN_USE, 1);
        send_command(OP_TICK, 8'h00, '0, '0, '0, '0, '0, '0);
        send_command(OP_SPAWN, 8'h00, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'hC000, 16'h6666);
        send_command(OP_SPAWN, 8'h00, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 16'h5555, 16'h6666);
        send_command(OP_READ, 8'h00, '0, '0, '0, '0, '0, '0);

        run_phase(8, 30, 110, 45, 35, 1'b0);
        run_phase(1, 0, 50, 40, 40, 1'b1);
        run_phase(511, 5, 60, 45, 30, 1'b0);
        run_phase(256, 12, 60, 40, 40, 1'b1);

        // Limit 255 with mostly ticks: a splash age climbs to its ceiling before the slot dies.
        drain();
        write_reg(REG_SLOTS_IN_USE, 3);
        write_reg(REG_SPLASH_LIMIT, 255);
        steady = 1'b0;
        send_falling_spawn();
        repeat (320) random_command(3, 88, 6);

        drain();
        repeat (300) @(negedge aclk);
        if (error_count == 0 && reports_pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
